>>> rtl/iwo_pkg.sv
// Shared types and constants for the interpolated wavetable oscillator.
package iwo_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned SampleW    = 16;
  localparam int unsigned FracW      = 16;
  localparam int unsigned PhaseW     = AddrW + FracW;
  localparam int unsigned RateW      = 24;
  localparam int unsigned GainW      = 16;
  localparam int unsigned GainFrac   = 14;
  localparam int unsigned OutW       = 19;
  localparam int unsigned AccW       = SampleW + FracW + 1;
  localparam int unsigned MulBW      = GainW + 2;
  localparam int unsigned ProdW      = AccW + MulBW;
  localparam int unsigned InDataW    = 56;
  localparam int unsigned InUserW    = 2;
  localparam int unsigned OutDataW   = 40;

  localparam logic [GainW-1:0] GainReset = 16'd2734;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdWrite  = 1'b1;
  localparam logic SelMain   = 1'b0;
  localparam logic SelPerc   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_A,
    ST_MUL_DM,
    ST_MUL_DP,
    ST_MUL_GM,
    ST_MUL_GP,
    ST_FIN
  } iwo_state_e;

endpackage

>>> rtl/iwo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module iwo_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/interpolated_wavetable_oscillator.sv
// Top level: dual wavetable oscillator with linear interpolation and gain.
//
//  channel  | signals                         | moves
//  ---------+---------------------------------+------------------------------------
//  s_axis   | tvalid tready tdata tuser       | sample or table-write request
//  m_axis   | tvalid tready tdata             | main and percussive sample
//  cfg      | cfg_we_i cfg_wdata_i            | output gain, Q2.14
//
// After reset both tables are cleared, one entry per cycle, while the input is not ready.
// A sample request runs as two table reads on the one read port of each
// table, then four passes through the shared 33x18 multiplier, then the result load.
// A table write goes straight to the result load. The result register frees the
// input side; the final load waits only while the previous result is still unaccepted.
module interpolated_wavetable_oscillator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [iwo_pkg::GainW-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // key_on[0], rate[24:1], table_addr[34:25], table_data[50:35], zero pad
  input  logic [iwo_pkg::InDataW-1:0]    s_axis_tdata,
  // command[0], table_select[1]
  input  logic [iwo_pkg::InUserW-1:0]    s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // main_sample[18:0], perc_sample[37:19], zero pad
  output logic [iwo_pkg::OutDataW-1:0]   m_axis_tdata
);

  import iwo_pkg::*;

  iwo_state_e state_q, state_d;

  logic [AddrW-1:0]       clr_q, clr_d;
  logic [PhaseW-1:0]      phase_q, phase_d;
  logic [AddrW-1:0]       nxt_q, nxt_d;
  logic [FracW-1:0]       frac_q, frac_d;
  logic [SampleW-1:0]     a_main_q, a_main_d;
  logic [SampleW-1:0]     a_perc_q, a_perc_d;
  logic [SampleW:0]       dp_q, dp_d;
  logic [AccW-1:0]        acc_q, acc_d;
  logic [ProdW-1:0]       prod_q, prod_d;
  logic [OutW-1:0]        main_res_q, main_res_d;
  logic                   is_wr_q, is_wr_d;
  logic                   out_valid_q, out_valid_d;
  logic [2*OutW-1:0]      out_data_q, out_data_d;
  logic [GainW-1:0]       gain_q;

  // request fields
  logic                   in_cmd, in_sel, in_key;
  logic [RateW-1:0]       in_rate;
  logic [AddrW-1:0]       in_addr;
  logic [SampleW-1:0]     in_wdata;
  logic                   accept;

  logic [PhaseW-1:0]      phase_eff;
  logic [PhaseW-1:0]      step;

  // ram ports
  logic                   we_main, we_perc;
  logic [AddrW-1:0]       waddr, raddr;
  logic [SampleW-1:0]     wdata, rd_main, rd_perc;

  // shared multiplier
  logic signed [AccW-1:0]  mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;

  logic                   out_free;
  logic [SampleW:0]       diff_main;

  assign in_cmd   = s_axis_tuser[0];
  assign in_sel   = s_axis_tuser[1];
  assign in_key   = s_axis_tdata[0];
  assign in_rate  = s_axis_tdata[RateW:1];
  assign in_addr  = s_axis_tdata[RateW+AddrW:RateW+1];
  assign in_wdata = s_axis_tdata[RateW+AddrW+SampleW:RateW+AddrW+1];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;

  assign phase_eff = in_key ? '0 : phase_q;
  assign step      = {{(PhaseW-RateW+2){in_rate[RateW-1]}}, in_rate[RateW-1:2]};

  assign diff_main = {rd_main[SampleW-1], rd_main} - {a_main_q[SampleW-1], a_main_q};

  function automatic logic [OutW-1:0] round_sat(input logic [ProdW-1:0] p);
    logic [ProdW-1:0]            s;
    logic [ProdW-FracW-GainFrac-1:0] y;
    logic [OutW-1:0]             r;
    s = p + (ProdW'(1) << (FracW + GainFrac - 1));
    y = s[ProdW-1:FracW+GainFrac];
    if (y[$high(y):OutW-1] == '0 || y[$high(y):OutW-1] == '1) begin
      r = y[OutW-1:0];
    end else if (y[$high(y)]) begin
      r = {1'b1, {(OutW-1){1'b0}}};
    end else begin
      r = {1'b0, {(OutW-1){1'b1}}};
    end
    return r;
  endfunction

  // ram write and read address selection
  always_comb begin
    if (state_q == ST_CLEAR) begin
      we_main = 1'b1;
      we_perc = 1'b1;
      waddr   = clr_q;
      wdata   = '0;
    end else begin
      we_main = accept & (in_cmd == CmdWrite) & (in_sel == SelMain);
      we_perc = accept & (in_cmd == CmdWrite) & (in_sel == SelPerc);
      waddr   = in_addr;
      wdata   = in_wdata;
    end
    raddr = (state_q == ST_IDLE) ? phase_eff[PhaseW-1:FracW] : nxt_q;
  end

  iwo_ram #(.Width(SampleW), .Depth(TableDepth)) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (we_main),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_main)
  );

  iwo_ram #(.Width(SampleW), .Depth(TableDepth)) u_perc_ram (
    .clk_i   (clk_i),
    .we_i    (we_perc),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_perc)
  );

  // multiplier operand select
  always_comb begin
    unique case (state_q)
      ST_MUL_DM: begin
        mul_a = $signed({{(AccW-SampleW-1){diff_main[SampleW]}}, diff_main});
        mul_b = $signed({{(MulBW-FracW){1'b0}}, frac_q});
      end
      ST_MUL_DP: begin
        mul_a = $signed({{(AccW-SampleW-1){dp_q[SampleW]}}, dp_q});
        mul_b = $signed({{(MulBW-FracW){1'b0}}, frac_q});
      end
      ST_MUL_GM, ST_MUL_GP: begin
        mul_a = $signed(acc_q);
        mul_b = $signed({{(MulBW-GainW){1'b0}}, gain_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    phase_d     = phase_q;
    nxt_d       = nxt_q;
    frac_d      = frac_q;
    a_main_d    = a_main_q;
    a_perc_d    = a_perc_q;
    dp_d        = dp_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    main_res_d  = main_res_q;
    is_wr_d     = is_wr_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(TableDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CmdWrite) begin
            is_wr_d = 1'b1;
            state_d = ST_FIN;
          end else begin
            is_wr_d = 1'b0;
            nxt_d   = phase_eff[PhaseW-1:FracW] + 1'b1;
            frac_d  = phase_eff[FracW-1:0];
            phase_d = phase_eff + step;
            state_d = ST_RD_A;
          end
        end
      end
      ST_RD_A: begin
        a_main_d = rd_main;
        a_perc_d = rd_perc;
        state_d  = ST_MUL_DM;
      end
      ST_MUL_DM: begin
        prod_d  = mul_p;
        dp_d    = {rd_perc[SampleW-1], rd_perc} - {a_perc_q[SampleW-1], a_perc_q};
        state_d = ST_MUL_DP;
      end
      ST_MUL_DP: begin
        prod_d  = mul_p;
        acc_d   = {a_main_q[SampleW-1], a_main_q, {FracW{1'b0}}} + prod_q[AccW-1:0];
        state_d = ST_MUL_GM;
      end
      ST_MUL_GM: begin
        prod_d  = mul_p;
        acc_d   = {a_perc_q[SampleW-1], a_perc_q, {FracW{1'b0}}} + prod_q[AccW-1:0];
        state_d = ST_MUL_GP;
      end
      ST_MUL_GP: begin
        prod_d     = mul_p;
        main_res_d = round_sat(prod_q);
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = is_wr_q ? '0 : {round_sat(prod_q), main_res_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      phase_q     <= '0;
      is_wr_q     <= 1'b0;
      out_valid_q <= 1'b0;
      gain_q      <= GainReset;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      phase_q     <= phase_d;
      is_wr_q     <= is_wr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q      <= nxt_d;
    frac_q     <= frac_d;
    a_main_q   <= a_main_d;
    a_perc_q   <= a_perc_d;
    dp_q       <= dp_d;
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    main_res_q <= main_res_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-2*OutW){1'b0}}, out_data_q};

`ifndef SYNTH
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("request accepted during table clear");

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && is_wr_q && out_free) |=> (m_axis_tvalid && m_axis_tdata == '0))
    else $error("table write produced nonzero result");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_cmd == CmdWrite) |=> $stable(phase_q))
    else $error("table write changed phase");

  a_read_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_A) |-> $past(accept))
    else $error("read sequence started without request");
`endif

endmodule
